FILE: src/lmfr_pkg.sv
// Package for the LIN master frame receiver: codes, types and helper functions.
package lmfr_pkg;

    localparam logic [7:0]  SYNC_BYTE      = 8'h55;
    localparam logic [3:0]  MAX_DATA_BYTES = 4'd8;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd255;
    localparam int          LMFR_QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SYNC,
        PH_IDECHO,
        PH_DATA,
        PH_CHECK
    } t_phase;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_BYTE,
        CMD_TICK,
        CMD_NOP
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_TX     = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] pid;
        logic [3:0] len;
        logic [7:0] rx_byte;
    } t_q_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef struct packed {
        logic timeout;
        logic sum_err;
        logic complete;
    } t_status;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_byte;
        logic [2:0] data_index;
        logic       break_before;
        logic       busy;
        t_status    status;
        logic       rejected;
        logic       last;
    } t_result;

    // Protected identifier: P0 in bit 6, inverted P1 in bit 7.
    function automatic logic [7:0] make_pid(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

    // 8-bit add with end-around carry.
    function automatic logic [7:0] add_carry(input logic [7:0] sum, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, sum} + {1'b0, b};
        return s[7:0] + {7'd0, s[8]};
    endfunction

endpackage

FILE: src/lmfr_if.sv
// Handshake channel interfaces: request input, result output and config write.
interface lmfr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [5:0] frame_id;
    logic [3:0] data_length;
    logic [7:0] rx_byte;

    modport source (output valid, operation, frame_id, data_length, rx_byte, input ready);
    modport sink   (input valid, operation, frame_id, data_length, rx_byte, output ready);
endinterface

interface lmfr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] out_byte;
    logic [2:0] data_index;
    logic       break_before;
    logic       busy_res;
    logic       complete;
    logic       checksum_error;
    logic       timeout_error;
    logic       rejected;
    logic       last;

    modport source (output valid, result_kind, out_byte, data_index, break_before, busy_res,
                    complete, checksum_error, timeout_error, rejected, last, input ready);
    modport sink   (input valid, result_kind, out_byte, data_index, break_before, busy_res,
                    complete, checksum_error, timeout_error, rejected, last, output ready);
endinterface

interface lmfr_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: src/lmfr_front.sv
// Front end: accepts requests, decodes the operation, builds the PID, clamps the length.
module lmfr_front (
    lmfr_in_if.sink              i_in,
    input  lmfr_pkg::t_q_status  i_q_status,
    output logic                 o_push,
    output lmfr_pkg::t_q_entry   o_entry
);
    import lmfr_pkg::*;

    assign i_in.ready = !i_q_status.full;
    assign o_push     = i_in.valid && !i_q_status.full;

    always_comb begin
        case (i_in.operation)
            OP_START: o_entry.cmd = CMD_START;
            OP_BYTE:  o_entry.cmd = CMD_BYTE;
            OP_TICK:  o_entry.cmd = CMD_TICK;
            default:  o_entry.cmd = CMD_NOP;
        endcase
        o_entry.pid     = make_pid(i_in.frame_id);
        o_entry.len     = (i_in.data_length > MAX_DATA_BYTES) ? MAX_DATA_BYTES
                                                              : i_in.data_length;
        o_entry.rx_byte = i_in.rx_byte;
    end

endmodule

FILE: src/lmfr_queue.sv
// Small register FIFO between the decode front end and the frame engine.
module lmfr_queue #(
    parameter int DEPTH = lmfr_pkg::LMFR_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  lmfr_pkg::t_q_entry   i_entry,
    input  logic                 i_pop,
    output lmfr_pkg::t_q_entry   o_head,
    output lmfr_pkg::t_q_status  o_status
);
    import lmfr_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_q_entry      r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == FULL_CNT);
    assign o_head         = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

FILE: src/lmfr_back.sv
// Frame engine: header emission, echo drop, data pass-through, checksum and timeout.
module lmfr_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lmfr_pkg::t_q_entry   i_head,
    input  lmfr_pkg::t_q_status  i_q_status,
    output logic                 o_pop,
    lmfr_cfg_if.sink             i_cfg,
    lmfr_out_if.source           o_out
);
    import lmfr_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_pid, n_pid;
    logic [7:0]  r_sum, n_sum;
    logic [3:0]  r_cnt, n_cnt;
    logic [3:0]  r_len, n_len;
    logic [15:0] r_ticks, n_ticks;
    t_status     r_status, n_status;
    logic [15:0] r_timeout;
    logic        r_pend, n_pend;
    logic        r_out_valid, n_out_valid;
    t_result     r_out, n_out;

    logic       out_free;
    logic       take;
    logic       busy;
    logic       sync_echo;
    logic       id_echo;
    t_phase     eff_phase;
    logic [3:0] cnt_inc;

    assign out_free = !r_out_valid || o_out.ready;
    assign take     = out_free && !r_pend && !i_q_status.empty;
    assign o_pop    = take;
    assign busy     = (r_phase != PH_IDLE);
    assign cnt_inc  = r_cnt + 4'd1;

    // Byte routing: at most one sync echo and one identifier echo are dropped.
    always_comb begin
        sync_echo = (r_phase == PH_SYNC) && (i_head.rx_byte == SYNC_BYTE);
        id_echo   = !sync_echo && ((r_phase == PH_SYNC) || (r_phase == PH_IDECHO))
                    && (i_head.rx_byte == r_pid);
        if ((r_phase == PH_SYNC) || (r_phase == PH_IDECHO)) begin
            eff_phase = (r_len == 4'd0) ? PH_CHECK : PH_DATA;
        end else begin
            eff_phase = r_phase;
        end
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (take) begin
            case (i_head.cmd)
                CMD_START: begin
                    if (!busy) n_phase = PH_SYNC;
                end
                CMD_BYTE: begin
                    if (busy) begin
                        if (sync_echo) begin
                            n_phase = PH_IDECHO;
                        end else if (id_echo) begin
                            n_phase = eff_phase;
                        end else if (eff_phase == PH_DATA) begin
                            n_phase = (cnt_inc >= r_len) ? PH_CHECK : PH_DATA;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                CMD_TICK: begin
                    if (busy && (r_ticks <= 16'd1)) n_phase = PH_IDLE;
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // Frame registers and result.
    always_comb begin
        n_pid       = r_pid;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_len       = r_len;
        n_ticks     = r_ticks;
        n_status    = r_status;
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (take) begin
            case (i_head.cmd)
                CMD_START: begin
                    if (!busy) begin
                        n_pid    = i_head.pid;
                        n_sum    = i_head.pid;
                        n_cnt    = 4'd0;
                        n_len    = i_head.len;
                        n_ticks  = r_timeout;
                        n_status = '0;
                        n_pend   = 1'b1;
                    end
                end
                CMD_BYTE: begin
                    if (busy && !sync_echo && !id_echo) begin
                        if (eff_phase == PH_DATA) begin
                            n_sum = add_carry(r_sum, i_head.rx_byte);
                            n_cnt = cnt_inc;
                        end else begin
                            n_status = '0;
                            if (~r_sum == i_head.rx_byte) n_status.complete = 1'b1;
                            else                          n_status.sum_err  = 1'b1;
                        end
                    end
                end
                CMD_TICK: begin
                    if (busy) begin
                        if (r_ticks <= 16'd1) begin
                            n_ticks  = '0;
                            n_status = '0;
                            n_status.timeout = 1'b1;
                        end else begin
                            n_ticks = r_ticks - 16'd1;
                        end
                    end
                end
                default: n_ticks = r_ticks;
            endcase
        end

        // Result for the item taken this cycle; post-update state.
        if (take) begin
            n_out_valid        = 1'b1;
            n_out.kind         = KIND_STATUS;
            n_out.out_byte     = 8'd0;
            n_out.data_index   = 3'd0;
            n_out.break_before = 1'b0;
            n_out.busy         = (n_phase != PH_IDLE);
            n_out.status       = n_status;
            n_out.rejected     = 1'b0;
            n_out.last         = 1'b1;
            case (i_head.cmd)
                CMD_START: begin
                    if (busy) begin
                        n_out.rejected = 1'b1;
                    end else begin
                        n_out.kind         = KIND_TX;
                        n_out.out_byte     = SYNC_BYTE;
                        n_out.break_before = 1'b1;
                        n_out.last         = 1'b0;
                    end
                end
                CMD_BYTE: begin
                    if (busy && !sync_echo && !id_echo && (eff_phase == PH_DATA)) begin
                        n_out.kind       = KIND_DATA;
                        n_out.out_byte   = i_head.rx_byte;
                        n_out.data_index = r_cnt[2:0];
                    end
                end
                default: n_out.kind = KIND_STATUS;
            endcase
        end else if (out_free && r_pend) begin
            // Second header byte: the protected identifier.
            n_pend             = 1'b0;
            n_out_valid        = 1'b1;
            n_out.kind         = KIND_TX;
            n_out.out_byte     = r_pid;
            n_out.data_index   = 3'd0;
            n_out.break_before = 1'b0;
            n_out.busy         = busy;
            n_out.status       = r_status;
            n_out.rejected     = 1'b0;
            n_out.last         = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_pid       <= '0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_len       <= '0;
            r_ticks     <= '0;
            r_status    <= '0;
            r_timeout   <= TIMEOUT_RESET;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_pid       <= n_pid;
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_len       <= n_len;
            r_ticks     <= n_ticks;
            r_status    <= n_status;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_timeout <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.result_kind    = r_out.kind;
    assign o_out.out_byte       = r_out.out_byte;
    assign o_out.data_index     = r_out.data_index;
    assign o_out.break_before   = r_out.break_before;
    assign o_out.busy_res       = r_out.busy;
    assign o_out.complete       = r_out.status.complete;
    assign o_out.checksum_error = r_out.status.sum_err;
    assign o_out.timeout_error  = r_out.status.timeout;
    assign o_out.rejected       = r_out.rejected;
    assign o_out.last           = r_out.last;

endmodule

FILE: src/lin_master_frame_receiver_unit.sv
// Top level of the LIN master frame receiver: front end, request queue, frame engine.
//
//  channel  | dir | handshake      | carries
//  ---------+-----+----------------+----------------------------------------------
//  i_in     | in  | valid / ready  | operation, frame_id, data_length, rx_byte
//  o_out    | out | valid / ready  | result_kind, out_byte, data_index, flags, last
//  i_cfg    | in  | valid / ready  | timeout_ticks (16 bits), always ready
//
//  One request per cycle enters while the queue has room; the engine retires one
//  queued request per cycle into the output register while that register is free.
//  A start request yields two results (sync with break, then PID), and the engine
//  takes no new request until the PID result has entered the output register.
//  Synchronous active-low reset clears phase, counters, flags, queue and output valid;
//  timeout_ticks resets to 255.
//  Output stalls back up through the queue to i_in.ready; no result is dropped.
module lin_master_frame_receiver_unit #(
    parameter int QUEUE_DEPTH = lmfr_pkg::LMFR_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lmfr_in_if.sink     i_in,
    lmfr_cfg_if.sink    i_cfg,
    lmfr_out_if.source  o_out
);
    import lmfr_pkg::*;

    t_q_entry  push_entry;
    t_q_entry  head_entry;
    t_q_status q_status;
    logic      push;
    logic      pop;

    // Decode and handshake on the request side.
    lmfr_front u_front (
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    // Decouples request acceptance from result backpressure.
    lmfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head_entry),
        .o_status (q_status)
    );

    // Frame state, checksum, timeout and result register.
    lmfr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_entry),
        .i_q_status (q_status),
        .o_pop      (pop),
        .i_cfg      (i_cfg),
        .o_out      (o_out)
    );

    // Sync byte taken: the PID transmit result follows right away.
    a_pid_follows_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.break_before)
        |=> (o_out.valid && (o_out.result_kind == KIND_TX) && !o_out.break_before))
        else $error("PID result did not follow sync result");

    // A rejected start only happens while a frame runs.
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.rejected) |-> o_out.busy_res)
        else $error("start rejected while idle");

    // Data bytes are passed on only mid-frame, as single final results.
    a_data_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.result_kind == KIND_DATA)) |-> (o_out.busy_res && o_out.last))
        else $error("data result outside a frame");

endmodule

FILE: dv/tb_top.sv
// Testbench for the LIN master frame receiver: frame traffic, timeout settings, checked results.
module tb_top;
    import lmfr_pkg::*;

    // Operation code that the block has no meaning for; it must answer with status only.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int ITEM_TARGET  = 750;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int REPORT_LIMIT = 40;
    localparam int NUM_SETTINGS = 7;

    // ------------------------------------------------------------------
    // Frame tracker: mirrors the engine state, predicts every result and
    // checks what comes out against the oldest prediction.
    // ------------------------------------------------------------------
    class lin_frame_tracker;
        t_result     pending_results[$];
        logic [15:0] timeout_setting;
        t_phase      phase;
        logic [7:0]  pid;
        logic [7:0]  frame_sum;
        logic [3:0]  data_seen;
        logic [3:0]  data_wanted;
        logic [15:0] ticks_left;
        t_status     flags;
        int          errors;
        int          reports;
        int          requests;
        int          results_checked;
        int          good_frames;
        int          sum_errors;
        int          timeouts;
        int          rejects;

        function new();
            timeout_setting = TIMEOUT_RESET;
            phase           = PH_IDLE;
            pid             = '0;
            frame_sum       = '0;
            data_seen       = '0;
            data_wanted     = '0;
            ticks_left      = '0;
            flags           = '0;
        endfunction

        // P0 = even parity over id bits 0,1,2,4; P1 = odd parity over bits 1,3,4,5.
        static function logic [7:0] protect_id(logic [5:0] id);
            logic p0;
            logic p1;
            p0 = ^(id & 6'b010111);
            p1 = ~^(id & 6'b111010);
            return {p1, p0, id};
        endfunction

        // Byte sum with the carry folded back into bit 0.
        static function logic [7:0] fold_add(logic [7:0] acc, logic [7:0] b);
            logic [8:0] s;
            s = {1'b0, acc} + {1'b0, b};
            if (s > 9'h0ff)
                s = s - 9'h0ff;
            return s[7:0];
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function bit engine_busy();
            return phase != PH_IDLE;
        endfunction

        function void set_timeout(logic [15:0] value);
            timeout_setting = value;
        endfunction

        // Busy and outcome flags reflect the state after the request.
        function void push_result(t_kind kind, logic [7:0] b, logic [2:0] idx,
                                  logic brk, logic rej, logic fin);
            t_result r;
            r.kind         = kind;
            r.out_byte     = b;
            r.data_index   = idx;
            r.break_before = brk;
            r.busy         = (phase != PH_IDLE);
            r.status       = flags;
            r.rejected     = rej;
            r.last         = fin;
            pending_results.push_back(r);
        endfunction

        function void note_request(logic [1:0] op, logic [5:0] id, logic [3:0] len,
                                   logic [7:0] rx);
            logic [2:0] idx;
            requests++;
            if (op == OP_START) begin
                if (phase != PH_IDLE) begin
                    rejects++;
                    push_result(KIND_STATUS, 8'h00, 3'd0, 1'b0, 1'b1, 1'b1);
                    return;
                end
                pid         = protect_id(id);
                frame_sum   = pid;
                data_seen   = '0;
                data_wanted = (len > MAX_DATA_BYTES) ? MAX_DATA_BYTES : len;
                ticks_left  = timeout_setting;
                flags       = '0;
                phase       = PH_SYNC;
                push_result(KIND_TX, SYNC_BYTE, 3'd0, 1'b1, 1'b0, 1'b0);
                push_result(KIND_TX, pid, 3'd0, 1'b0, 1'b0, 1'b1);
                return;
            end
            if (op == OP_BYTE && phase != PH_IDLE) begin
                // Echo stages fall through when the byte does not match.
                if (phase == PH_SYNC) begin
                    phase = PH_IDECHO;
                    if (rx == SYNC_BYTE) begin
                        push_result(KIND_STATUS, 8'h00, 3'd0, 1'b0, 1'b0, 1'b1);
                        return;
                    end
                end
                if (phase == PH_IDECHO) begin
                    phase = (data_wanted == 0) ? PH_CHECK : PH_DATA;
                    if (rx == pid) begin
                        push_result(KIND_STATUS, 8'h00, 3'd0, 1'b0, 1'b0, 1'b1);
                        return;
                    end
                end
                if (phase == PH_DATA) begin
                    idx       = data_seen[2:0];
                    frame_sum = fold_add(frame_sum, rx);
                    data_seen = data_seen + 4'd1;
                    if (data_seen >= data_wanted)
                        phase = PH_CHECK;
                    push_result(KIND_DATA, rx, idx, 1'b0, 1'b0, 1'b1);
                    return;
                end
                flags = '0;
                if (~frame_sum == rx) begin
                    flags.complete = 1'b1;
                    good_frames++;
                end else begin
                    flags.sum_err = 1'b1;
                    sum_errors++;
                end
                phase = PH_IDLE;
                push_result(KIND_STATUS, 8'h00, 3'd0, 1'b0, 1'b0, 1'b1);
                return;
            end
            if (op == OP_TICK && phase != PH_IDLE) begin
                if (ticks_left <= 16'd1) begin
                    ticks_left    = '0;
                    flags         = '0;
                    flags.timeout = 1'b1;
                    phase         = PH_IDLE;
                    timeouts++;
                end else begin
                    ticks_left = ticks_left - 16'd1;
                end
            end
            // Idle bytes, idle ticks, busy ticks and unused codes: status only.
            push_result(KIND_STATUS, 8'h00, 3'd0, 1'b0, 1'b0, 1'b1);
        endfunction

        function void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                if (reports < REPORT_LIMIT)
                    $display("%0t: %s mismatch, expected %0h, actual %0h",
                             $time, name, exp_v, act_v);
                reports++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                errors++;
                if (reports < REPORT_LIMIT)
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                reports++;
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            check_field("result_kind", 16'(want.kind), 16'(got.kind));
            check_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
            check_field("data_index", 16'(want.data_index), 16'(got.data_index));
            check_field("break_before", 16'(want.break_before), 16'(got.break_before));
            check_field("busy_res", 16'(want.busy), 16'(got.busy));
            check_field("complete", 16'(want.status.complete), 16'(got.status.complete));
            check_field("checksum_error", 16'(want.status.sum_err), 16'(got.status.sum_err));
            check_field("timeout_error", 16'(want.status.timeout), 16'(got.status.timeout));
            check_field("rejected", 16'(want.rejected), 16'(got.rejected));
            check_field("last", 16'(want.last), 16'(got.last));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, channels and the block under test.
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    lmfr_in_if  req_if();
    lmfr_out_if res_if();
    lmfr_cfg_if cfg_if();

    lin_master_frame_receiver_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .i_cfg   (cfg_if),
        .o_out   (res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    lin_frame_tracker tracker = new();

    // Tracks whether request valid is currently driven high, so that it is
    // never lowered and raised within one time step.
    bit req_up;
    bit src_quiet;
    bit sink_quiet;
    int cycle_count;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, tracker.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one request after a random gap and wait for it to be taken.
    // Valid stays up on return; the next call or a hold lowers it.
    task automatic send_req(input logic [1:0] op, input logic [5:0] id,
                            input logic [3:0] len, input logic [7:0] rx);
        int gap;
        gap = src_quiet ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 29) == 0)
            src_quiet = !src_quiet;
        if (gap > 0) begin
            if (req_up) begin
                req_if.valid <= 1'b0;
                req_up = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.operation   <= op;
        req_if.frame_id    <= id;
        req_if.data_length <= len;
        req_if.rx_byte     <= rx;
        req_up = 1'b1;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        tracker.note_request(op, id, len, rx);
    endtask

    // Sender goes quiet until every predicted result has been seen.
    task automatic hold_until_drained();
        if (req_up) begin
            req_if.valid <= 1'b0;
            req_up = 1'b0;
        end
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        tracker.set_timeout(value);
    endtask

    // Traffic that lands between frame bytes: ticks, starts while busy, unused codes.
    task automatic maybe_interject();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            send_req(OP_TICK, 6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)),
                     8'($urandom_range(0, 255)));
        else if (pick < 19)
            send_req(OP_START, 6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)),
                     8'($urandom_range(0, 255)));
        else if (pick < 21)
            send_req(OP_UNUSED, 6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)),
                     8'($urandom_range(0, 255)));
    endtask

    // One master frame as it would appear on the bus, mostly well formed:
    // header echoes, data bytes, then the enhanced checksum.
    task automatic run_frame();
        logic [5:0] id;
        logic [3:0] len;
        logic [7:0] pid;
        logic [7:0] sum;
        logic [7:0] b;
        int         n_data;
        id  = 6'($urandom_range(0, 63));
        // Mostly legal lengths, sometimes zero or above the maximum.
        len = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(1, 8));
        n_data = int'((len > MAX_DATA_BYTES) ? MAX_DATA_BYTES : len);
        pid = lin_frame_tracker::protect_id(id);
        sum = pid;
        send_req(OP_START, id, len, 8'($urandom_range(0, 255)));
        maybe_interject();
        b = ($urandom_range(0, 9) != 0) ? SYNC_BYTE : 8'($urandom_range(0, 255));
        send_req(OP_BYTE, 6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)), b);
        maybe_interject();
        b = ($urandom_range(0, 9) != 0) ? pid : 8'($urandom_range(0, 255));
        send_req(OP_BYTE, 6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)), b);
        maybe_interject();
        for (int i = 0; i < n_data; i++) begin
            b   = 8'($urandom_range(0, 255));
            sum = lin_frame_tracker::fold_add(sum, b);
            send_req(OP_BYTE, 6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)), b);
            maybe_interject();
        end
        b = ~sum;
        if ($urandom_range(0, 6) == 0)
            b = b ^ 8'($urandom_range(1, 255));
        send_req(OP_BYTE, 6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)), b);
    endtask

    // Result side: random stalls per result, with quiet stretches.
    initial begin
        int      stall;
        t_result got;
        @(posedge i_rst_n);
        forever begin
            stall = sink_quiet ? 0 : $urandom_range(0, 19);
            if ($urandom_range(0, 29) == 0)
                sink_quiet = !sink_quiet;
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
            got.kind           = t_kind'(res_if.result_kind);
            got.out_byte       = res_if.out_byte;
            got.data_index     = res_if.data_index;
            got.break_before   = res_if.break_before;
            got.busy           = res_if.busy_res;
            got.status.complete = res_if.complete;
            got.status.sum_err = res_if.checksum_error;
            got.status.timeout = res_if.timeout_error;
            got.rejected       = res_if.rejected;
            got.last           = res_if.last;
            tracker.check_result(got);
        end
    end

    // Stimulus sequence.
    initial begin
        logic [15:0] timeout_plan [NUM_SETTINGS];
        logic [7:0]  long_data [8];
        logic [7:0]  sum;
        int          base;
        int          target;
        int          pick;

        req_if.valid       <= 1'b0;
        req_if.operation   <= OP_START;
        req_if.frame_id    <= '0;
        req_if.data_length <= '0;
        req_if.rx_byte     <= '0;
        res_if.ready       <= 1'b0;
        cfg_if.valid       <= 1'b0;
        cfg_if.data        <= '0;
        i_rst_n            <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, at the reset timeout.
        // Requests that find the engine idle.
        send_req(OP_BYTE, 6'h00, 4'h0, 8'hff);
        send_req(OP_TICK, 6'h00, 4'h0, 8'h00);
        send_req(OP_UNUSED, 6'h3f, 4'hf, 8'hff);
        // Zero-length frame: echoes, then the checksum straight away.
        send_req(OP_START, 6'h00, 4'h0, 8'h00);
        send_req(OP_START, 6'h3f, 4'hf, 8'hff);   // busy, must be rejected
        send_req(OP_BYTE, 6'h00, 4'h0, SYNC_BYTE);
        send_req(OP_BYTE, 6'h00, 4'h0, lin_frame_tracker::protect_id(6'h00));
        send_req(OP_BYTE, 6'h00, 4'h0, ~lin_frame_tracker::protect_id(6'h00));
        // Oversized length saturates to eight; no echoes at all, so the first
        // byte falls through both echo stages into data. Heavy carry folding.
        long_data = '{8'haa, 8'h00, 8'hff, 8'h80, 8'h01, 8'h7f, 8'hfe, 8'h55};
        sum = lin_frame_tracker::protect_id(6'h3f);
        send_req(OP_START, 6'h3f, 4'hf, 8'h00);
        foreach (long_data[i]) begin
            sum = lin_frame_tracker::fold_add(sum, long_data[i]);
            send_req(OP_BYTE, 6'h3f, 4'hf, long_data[i]);
        end
        send_req(OP_BYTE, 6'h3f, 4'hf, ~sum);
        // Busy tick and unused code, sync echo but a wrong identifier echo,
        // then a bad checksum.
        send_req(OP_START, 6'h2a, 4'h1, 8'h00);
        send_req(OP_TICK, 6'h2a, 4'h1, 8'h00);
        send_req(OP_UNUSED, 6'h2a, 4'h1, 8'h00);
        send_req(OP_BYTE, 6'h2a, 4'h1, SYNC_BYTE);
        send_req(OP_BYTE, 6'h2a, 4'h1, 8'h00);
        send_req(OP_BYTE, 6'h2a, 4'h1, 8'h00);
        hold_until_drained();

        // Random part over several timeout settings, extremes included.
        timeout_plan = '{16'd0, 16'd1, 16'hffff, 16'd6, 16'd25, 16'd0, TIMEOUT_RESET};
        timeout_plan[5] = 16'($urandom_range(2, 100));
        base = tracker.requests;
        for (int p = 0; p < NUM_SETTINGS; p++) begin
            // Settle after the last result before touching the register.
            repeat (4) @(posedge i_clk);
            write_timeout(timeout_plan[p]);
            target = base + (p + 1) * ITEM_TARGET / NUM_SETTINGS;
            while (tracker.requests < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    run_frame();
                else
                    send_req(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                             4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 29) == 0)
                    hold_until_drained();
            end
            // Close any frame left open so the next setting starts from idle.
            while (tracker.engine_busy())
                send_req(OP_BYTE, 6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)),
                         8'($urandom_range(0, 255)));
            hold_until_drained();
        end

        // Let any stray result show up before the verdict.
        repeat (20) @(posedge i_clk);
        $display("Sent %0d requests over %0d timeout settings; %0d results checked",
                 tracker.requests, NUM_SETTINGS + 1, tracker.results_checked);
        $display("Frames: %0d good, %0d checksum errors, %0d timeouts, %0d rejected starts",
                 tracker.good_frames, tracker.sum_errors, tracker.timeouts, tracker.rejects);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
src/lmfr_pkg.sv
src/lmfr_if.sv
src/lmfr_front.sv
src/lmfr_queue.sv
src/lmfr_back.sv
src/lin_master_frame_receiver_unit.sv
dv/tb_top.sv
